@@ hdl/sdfpe_pkg.sv @@
// sdfpe_pkg: shared types and constants for the sdf primitive evaluator
// no dependencies; imported by the core, the square-root unit and the checker
package sdfpe_pkg;

  typedef enum logic [1:0] {
    KIND_BOX      = 2'd0,
    KIND_SPHERE   = 2'd1,
    KIND_CAPSULE  = 2'd2,
    KIND_CYLINDER = 2'd3
  } shape_kind_e;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_CENTER_Z   = 3'd3,
    REG_ROTATION   = 3'd4,
    REG_DIM_A      = 3'd5,
    REG_DIM_B      = 3'd6,
    REG_DIMS_CD    = 3'd7
  } reg_idx_e;

  // signed working width for distances and box/cylinder terms
  localparam int unsigned DW = 40;
  // rotated offset width, signed
  localparam int unsigned RW = 35;
  // norm operand width, unsigned
  localparam int unsigned VW = 35;
  // sum of squares width
  localparam int unsigned SQ_W = 72;
  // rounded norm width
  localparam int unsigned NW = SQ_W / 2 + 1;

  localparam int unsigned TUSER_SAT   = 0;
  localparam int unsigned TUSER_DEGEN = 1;

endpackage

@@ hdl/sdf_primitive_evaluator_core.sv @@
// sdf_primitive_evaluator_core: signed distance from a query point to a configured primitive
// depends on sdfpe_pkg and sdfpe_sqrt; apb register file plus streaming datapath
// an input transaction reaches output valid through the datapath registers and two pipelined square roots
// throughput one transaction per cycle; the whole pipe stalls only while the output waits
// rotation matrix follows a register write through the quaternion product registers and the matrix registers
// rst_ni is asynchronous active low; it clears valid bits and loads register defaults
module sdf_primitive_evaluator_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // distance
  output logic [1:0]   m_axis_tuser    // saturated, degenerate
);
  import sdfpe_pkg::*;

  // registers
  logic [2:0]         shape_mode_q;
  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [63:0]        rotation_q;
  logic [30:0]        dim_a_q, dim_b_q;
  logic [63:0]        dims_cd_q;
  logic               cfg_wr;
  shape_kind_e        kind;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign kind   = shape_kind_e'(shape_mode_q[1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= 3'd1;
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      rotation_q   <= 64'd16384;
      dim_a_q      <= 31'(64'd1 << FRAC_BITS);
      dim_b_q      <= '0;
      dims_cd_q    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[5:3]))
        REG_SHAPE_MODE: shape_mode_q <= pwdata[2:0];
        REG_CENTER_X:   center_x_q   <= pwdata[31:0];
        REG_CENTER_Y:   center_y_q   <= pwdata[31:0];
        REG_CENTER_Z:   center_z_q   <= pwdata[31:0];
        REG_ROTATION:   rotation_q   <= pwdata;
        REG_DIM_A:      dim_a_q      <= pwdata[30:0];
        REG_DIM_B:      dim_b_q      <= pwdata[30:0];
        REG_DIMS_CD:    dims_cd_q    <= pwdata;
        default:        shape_mode_q <= shape_mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[5:3]))
      REG_SHAPE_MODE: prdata = {61'd0, shape_mode_q};
      REG_CENTER_X:   prdata = {32'd0, center_x_q};
      REG_CENTER_Y:   prdata = {32'd0, center_y_q};
      REG_CENTER_Z:   prdata = {32'd0, center_z_q};
      REG_ROTATION:   prdata = rotation_q;
      REG_DIM_A:      prdata = {33'd0, dim_a_q};
      REG_DIM_B:      prdata = {33'd0, dim_b_q};
      REG_DIMS_CD:    prdata = dims_cd_q;
      default:        prdata = '0;
    endcase
  end

  // rotation matrix from the quaternion
  function automatic logic signed [29:0] clamp_unit(input logic signed [33:0] v);
    logic signed [29:0] r;
    if (v > 34'sd268435456) begin
      r = 30'sd268435456;
    end else if (v < -34'sd268435456) begin
      r = -30'sd268435456;
    end else begin
      r = v[29:0];
    end
    return r;
  endfunction

  logic signed [33:0] qw, qx, qy, qz;
  logic signed [33:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic signed [29:0] m_q [9];

  assign qw = 34'($signed(rotation_q[15:0]));
  assign qx = 34'($signed(rotation_q[31:16]));
  assign qy = 34'($signed(rotation_q[47:32]));
  assign qz = 34'($signed(rotation_q[63:48]));

  always_ff @(posedge clk_i) begin
    ww_q <= qw * qw;
    xx_q <= qx * qx;
    yy_q <= qy * qy;
    zz_q <= qz * qz;
    xy_q <= qx * qy;
    wz_q <= qw * qz;
    xz_q <= qx * qz;
    wy_q <= qw * qy;
    yz_q <= qy * qz;
    wx_q <= qw * qx;
    m_q[0] <= clamp_unit(ww_q + xx_q - yy_q - zz_q);
    m_q[1] <= clamp_unit((xy_q + wz_q) <<< 1);
    m_q[2] <= clamp_unit((xz_q - wy_q) <<< 1);
    m_q[3] <= clamp_unit((xy_q - wz_q) <<< 1);
    m_q[4] <= clamp_unit(ww_q - xx_q + yy_q - zz_q);
    m_q[5] <= clamp_unit((yz_q + wx_q) <<< 1);
    m_q[6] <= clamp_unit((xz_q + wy_q) <<< 1);
    m_q[7] <= clamp_unit((yz_q - wx_q) <<< 1);
    m_q[8] <= clamp_unit(ww_q - xx_q - yy_q + zz_q);
  end

  // pipeline control
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic c1_q, c2_q, c3_q, c4_q, f1_q;
  logic sq1_vld, sq2_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      c1_q <= 1'b0; c2_q <= 1'b0; c3_q <= 1'b0; c4_q <= 1'b0;
      f1_q <= 1'b0; out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      c1_q <= sq1_vld; c2_q <= c1_q; c3_q <= c2_q; c4_q <= c3_q;
      f1_q <= sq2_vld; out_valid_q <= f1_q;
    end
  end

  // datapath
  logic signed [32:0]   d_q [3];
  logic signed [62:0]   prod_q [9];
  logic signed [32:0]   dp_q [3];
  logic signed [RW-1:0] r_q [3];
  logic [33:0]          mag_q [3];
  logic signed [DW-1:0] t1_q, t2_q;
  logic signed [DW-1:0] e0_q, e1_q, e2_q, ec1_q, px_q;
  logic [33:0]          mag5_q [3];
  logic [VW-1:0]        v_q [3];
  logic signed [DW-1:0] aux_q;
  logic [2*VW-1:0]      sq_q [3];
  logic signed [DW-1:0] aux7_q, aux8_q;
  logic [SQ_W-1:0]      sum_q;
  logic [NW-1:0]        n1;
  logic [DW-1:0]        sq1_side;
  logic signed [DW-1:0] g1_q, g2_q;
  logic [VW-1:0]        w_q [2];
  logic signed [DW-1:0] g1c2_q, g2c2_q;
  logic [2*VW-1:0]      sq2_q [2];
  logic signed [DW-1:0] g1c3_q, g2c3_q;
  logic [SQ_W-1:0]      sum2_q;
  logic signed [DW-1:0] g1c4_q, g2c4_q;
  logic [NW-1:0]        n2;
  logic [2*DW-1:0]      sq2_side;
  logic signed [DW-1:0] phi_q;
  logic [31:0]          dist_q;
  logic                 sat_q, degen_q;

  logic signed [DW-1:0] dim_a_s, dim_b_s, lowc_s, highc_s;
  assign dim_a_s = $signed({9'd0, dim_a_q});
  assign dim_b_s = $signed({9'd0, dim_b_q});
  assign lowc_s  = $signed({8'd0, dims_cd_q[31:0]});
  assign highc_s = $signed({8'd0, dims_cd_q[63:32]});

  logic signed [62:0]   mx [9];
  logic signed [62:0]   dx [3];
  logic signed [64:0]   acc [3];
  logic signed [RW-1:0] px_abs;
  logic signed [DW-1:0] maxe01;
  logic signed [DW-1:0] n1_s, n2_s, gmax, phi_f, phi_n;

  function automatic logic signed [DW-1:0] g1c3_side();
    return $signed(sq2_side[DW-1:0]);
  endfunction

  function automatic logic signed [DW-1:0] g2c3_side();
    return $signed(sq2_side[2*DW-1:DW]);
  endfunction

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mx[k] = 63'(m_q[k]);
    end
    for (int j = 0; j < 3; j++) begin
      dx[j] = 63'(d_q[j]);
    end
    for (int i = 0; i < 3; i++) begin
      acc[i] = 65'(prod_q[3*i]) + 65'(prod_q[3*i+1]) + 65'(prod_q[3*i+2])
             + 65'sd134217728;
    end
    px_abs = px_q[RW-1:0];
    px_abs = px_abs[RW-1] ? -px_abs : px_abs;
    maxe01 = (e0_q > e1_q) ? e0_q : e1_q;
    n1_s   = $signed(DW'(n1));
    n2_s   = $signed(DW'(n2));
    gmax   = (g1c3_side() > g2c3_side()) ? g1c3_side() : g2c3_side();
    phi_f  = (kind == KIND_CYLINDER)
           ? ((gmax < 0) ? gmax : DW'(0)) + n2_s - dim_b_s
           : $signed(sq2_side[DW-1:0]);
    phi_n  = shape_mode_q[2] ? -phi_q : phi_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // subtract centre
      d_q[0] <= 33'($signed(s_axis_tdata[31:0])) - 33'(center_x_q);
      d_q[1] <= 33'($signed(s_axis_tdata[63:32])) - 33'(center_y_q);
      d_q[2] <= 33'($signed(s_axis_tdata[95:64])) - 33'(center_z_q);
      // matrix products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[3*i+j] <= mx[3*i+j] * dx[j];
        end
        dp_q[i] <= d_q[i];
      end
      // dot products, rounded
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= (kind == KIND_SPHERE) ? RW'(dp_q[i]) : acc[i][RW+27:28];
      end
      // magnitudes and capsule offsets
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= r_q[i][RW-1] ? 34'(-r_q[i]) : 34'(r_q[i]);
      end
      t1_q <= DW'(r_q[0]) - dim_b_s;
      t2_q <= DW'(r_q[0]) + dim_b_s;
      // per-axis terms
      e0_q  <= $signed(DW'(mag_q[0])) - dim_a_s;
      e1_q  <= $signed(DW'(mag_q[1])) - dim_b_s;
      e2_q  <= $signed(DW'(mag_q[2])) - lowc_s;
      ec1_q <= $signed(DW'(mag_q[1])) - lowc_s;
      px_q  <= (t1_q > 0) ? t1_q : ((t2_q < 0) ? t2_q : DW'(0));
      for (int i = 0; i < 3; i++) begin
        mag5_q[i] <= mag_q[i];
      end
      // norm operands
      case (kind)
        KIND_BOX: begin
          v_q[0] <= (e0_q > 0) ? e0_q[VW-1:0] : '0;
          v_q[1] <= (e1_q > 0) ? e1_q[VW-1:0] : '0;
          v_q[2] <= (e2_q > 0) ? e2_q[VW-1:0] : '0;
          aux_q  <= (maxe01 > e2_q) ? maxe01 : e2_q;
        end
        KIND_CAPSULE: begin
          v_q[0] <= VW'(px_abs);
          v_q[1] <= VW'(mag5_q[1]);
          v_q[2] <= VW'(mag5_q[2]);
          aux_q  <= '0;
        end
        KIND_CYLINDER: begin
          v_q[0] <= VW'(mag5_q[0]);
          v_q[1] <= VW'(mag5_q[2]);
          v_q[2] <= '0;
          aux_q  <= ec1_q;
        end
        default: begin
          v_q[0] <= VW'(mag5_q[0]);
          v_q[1] <= VW'(mag5_q[1]);
          v_q[2] <= VW'(mag5_q[2]);
          aux_q  <= '0;
        end
      endcase
      // squares and sum
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= v_q[i] * v_q[i];
      end
      aux7_q <= aux_q;
      sum_q  <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
      aux8_q <= aux7_q;
      // first norm done
      case (kind)
        KIND_CYLINDER: g1_q <= n1_s - dim_a_s + dim_b_s;
        KIND_BOX: begin
          g1_q <= (($signed(sq1_side) < 0) ? $signed(sq1_side) : DW'(0)) + n1_s - highc_s;
        end
        default:       g1_q <= n1_s - dim_a_s;
      endcase
      g2_q <= $signed(sq1_side);
      // cylinder second norm operands
      w_q[0] <= ((kind == KIND_CYLINDER) && (g1_q > 0)) ? g1_q[VW-1:0] : '0;
      w_q[1] <= ((kind == KIND_CYLINDER) && (g2_q > 0)) ? g2_q[VW-1:0] : '0;
      g1c2_q <= g1_q;
      g2c2_q <= g2_q;
      sq2_q[0] <= w_q[0] * w_q[0];
      sq2_q[1] <= w_q[1] * w_q[1];
      g1c3_q <= g1c2_q;
      g2c3_q <= g2c2_q;
      sum2_q <= SQ_W'(sq2_q[0]) + SQ_W'(sq2_q[1]);
      g1c4_q <= g1c3_q;
      g2c4_q <= g2c3_q;
      // final distance, sign and clamp
      phi_q <= phi_f;
      if (phi_n > $signed(DW'(32'h7fffffff))) begin
        dist_q <= 32'h7fffffff;
        sat_q  <= 1'b1;
      end else if (phi_n < -$signed(DW'(33'h080000000))) begin
        dist_q <= 32'h80000000;
        sat_q  <= 1'b1;
      end else begin
        dist_q <= phi_n[31:0];
        sat_q  <= 1'b0;
      end
      degen_q <= (kind == KIND_CAPSULE) && (dim_b_q == '0);
    end
  end

  sdfpe_sqrt #(
    .RAD_W  (SQ_W),
    .SIDE_W (DW)
  ) u_sqrt_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .rad_i   (sum_q),
    .side_i  (aux8_q),
    .valid_o (sq1_vld),
    .root_o  (n1),
    .side_o  (sq1_side)
  );

  sdfpe_sqrt #(
    .RAD_W  (SQ_W),
    .SIDE_W (2 * DW)
  ) u_sqrt_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c4_q),
    .rad_i   (sum2_q),
    .side_i  ({g2c4_q, g1c4_q}),
    .valid_o (sq2_vld),
    .root_o  (n2),
    .side_o  (sq2_side)
  );

  assign m_axis_tvalid            = out_valid_q;
  assign m_axis_tdata             = dist_q;
  assign m_axis_tuser[TUSER_SAT]   = sat_q;
  assign m_axis_tuser[TUSER_DEGEN] = degen_q;

endmodule

@@ hdl/sdfpe_sqrt.sv @@
// sdfpe_sqrt: pipelined square root, one result bit per stage, rounded to nearest
// depends on sdfpe_pkg for default widths; carries a sideband word beside the data
module sdfpe_sqrt #(
  parameter int unsigned RAD_W  = sdfpe_pkg::SQ_W,
  parameter int unsigned SIDE_W = sdfpe_pkg::DW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RAD_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [RAD_W/2:0]      root_o,
  output logic [SIDE_W-1:0]     side_o
);
  import sdfpe_pkg::*;

  localparam int unsigned RTW = RAD_W / 2;

  logic [RTW:0]      rem_q  [RTW];
  logic [RTW-1:0]    root_q [RTW];
  logic [RAD_W-1:0]  rad_q  [RTW];
  logic [SIDE_W-1:0] side_q [RTW];
  logic              vld_q  [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RTW:0]      rem_in;
    logic [RTW-1:0]    root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RTW+2:0]    cur;
    logic [RTW+2:0]    trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (RTW+1)'(cur - trial) : cur[RTW:0];
        root_q[k] <= {root_in[RTW-2:0], take};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  logic              out_vld_q;
  logic [RTW:0]      root_out_q;
  logic [SIDE_W-1:0] side_out_q;
  logic              round_up;

  assign round_up = (rem_q[RTW-1] > {1'b0, root_q[RTW-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[RTW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_out_q <= {1'b0, root_q[RTW-1]} + (RTW+1)'(round_up);
      side_out_q <= side_q[RTW-1];
    end
  end

  assign valid_o = out_vld_q;
  assign root_o  = root_out_q;
  assign side_o  = side_out_q;

endmodule

@@ hdl/sdfpe_checker.sv @@
// sdfpe_checker: port-level assertions for the sdf primitive evaluator core
// depends on sdfpe_pkg; bound to sdf_primitive_evaluator_core below
module sdfpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import sdfpe_pkg::*;

  // held output transaction stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  // held output transaction keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // input side only stalls when the output register is full and not taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free output");

  // clamped distances sit on the rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_SAT] |->
      (m_axis_tdata == 32'h7fffffff) || (m_axis_tdata == 32'h80000000))
    else $error("saturated flag without clamped distance");

endmodule

bind sdf_primitive_evaluator_core sdfpe_checker u_sdfpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ verif/tb_sdf_primitive_evaluator_core.sv @@
// tb_sdf_primitive_evaluator_core: self-checking bench for the sdf primitive evaluator
// depends on sdfpe_pkg and sdf_primitive_evaluator_core; predicts each distance in the bench
// apb setup per phase, stream driver and monitor with random idling on both sides
module tb_sdf_primitive_evaluator_core;
  import sdfpe_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // point_x, point_y, point_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;        // distance
  logic [1:0]   m_axis_tuser;        // saturated, degenerate

  sdf_primitive_evaluator_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the register file
  logic [2:0]  mode_q = 3'd1;
  logic [31:0] cx_q = '0, cy_q = '0, cz_q = '0;
  logic [63:0] rot_q = 64'd16384;
  logic [30:0] da_q = 31'd65536, db_q = '0;
  logic [63:0] dcd_q = '0;

  logic [95:0] point_queue[$];
  logic [33:0] distance_queue[$];   // degenerate, saturated, distance
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pending = 0;
  bit          took = 1'b0;

  function automatic longint vec_len(longint a, longint b, longint c);
    logic [127:0] n, cand, one_up;
    logic [63:0]  ma, mb, mc, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    n = 128'(ma) * 128'(ma) + 128'(mb) * 128'(mb) + 128'(mc) * 128'(mc);
    r = '0;
    for (int bit_i = 47; bit_i >= 0; bit_i--) begin
      cand = 128'(r | (64'd1 << bit_i));
      if (cand * cand <= n) r = r | (64'd1 << bit_i);
    end
    one_up = 128'(r) * 128'(r) + 128'(r) + 128'd1;
    if (n >= one_up) r = r + 1;
    return longint'(r);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > (64'sd1 <<< 28)) return 64'sd1 <<< 28;
    if (v < -(64'sd1 <<< 28)) return -(64'sd1 <<< 28);
    return v;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [33:0] shape_distance(logic [95:0] pt);
    longint d[3], r[3], m[9], phi, qw, qx, qy, qz, e0, e1, e2, px, a, b, lowc, highc;
    logic sat, degen;
    shape_kind_e kind;
    kind  = shape_kind_e'(mode_q[1:0]);
    a     = longint'(da_q);
    b     = longint'(db_q);
    lowc  = longint'(dcd_q[31:0]);
    highc = longint'(dcd_q[63:32]);
    sat   = 1'b0;
    degen = 1'b0;
    d[0] = longint'(signed'(pt[31:0])) - longint'(signed'(cx_q));
    d[1] = longint'(signed'(pt[63:32])) - longint'(signed'(cy_q));
    d[2] = longint'(signed'(pt[95:64])) - longint'(signed'(cz_q));
    if (kind == KIND_SPHERE) begin
      phi = vec_len(d[0], d[1], d[2]) - a;
    end else begin
      qw = longint'(signed'(rot_q[15:0]));
      qx = longint'(signed'(rot_q[31:16]));
      qy = longint'(signed'(rot_q[47:32]));
      qz = longint'(signed'(rot_q[63:48]));
      m[0] = clamp_unit(qw*qw + qx*qx - qy*qy - qz*qz);
      m[1] = clamp_unit(2 * (qx*qy + qw*qz));
      m[2] = clamp_unit(2 * (qx*qz - qw*qy));
      m[3] = clamp_unit(2 * (qx*qy - qw*qz));
      m[4] = clamp_unit(qw*qw - qx*qx + qy*qy - qz*qz);
      m[5] = clamp_unit(2 * (qy*qz + qw*qx));
      m[6] = clamp_unit(2 * (qx*qz + qw*qy));
      m[7] = clamp_unit(2 * (qy*qz - qw*qx));
      m[8] = clamp_unit(qw*qw - qx*qx - qy*qy + qz*qz);
      for (int k = 0; k < 3; k++)
        r[k] = (m[3*k]*d[0] + m[3*k+1]*d[1] + m[3*k+2]*d[2] + (64'sd1 <<< 27)) >>> 28;
      case (kind)
        KIND_BOX: begin
          e0 = ((r[0] < 0) ? -r[0] : r[0]) - a;
          e1 = ((r[1] < 0) ? -r[1] : r[1]) - b;
          e2 = ((r[2] < 0) ? -r[2] : r[2]) - lowc;
          phi = lmin(lmax(lmax(e0, e1), e2), 0)
              + vec_len(lmax(e0, 0), lmax(e1, 0), lmax(e2, 0)) - highc;
        end
        KIND_CAPSULE: begin
          px = r[0] + b;
          if (px > 2 * b) px = px - 2 * b;
          else if (px >= 0) px = 0;
          phi = vec_len(px, r[1], r[2]) - a;
          degen = (b == 0);
        end
        default: begin
          e0 = vec_len(r[0], r[2], 0) - a + b;
          e1 = ((r[1] < 0) ? -r[1] : r[1]) - lowc;
          phi = lmin(lmax(e0, e1), 0) + vec_len(lmax(e0, 0), lmax(e1, 0), 0) - b;
        end
      endcase
    end
    if (mode_q[2]) phi = -phi;
    if (phi > 64'sd2147483647) begin
      phi = 64'sd2147483647;
      sat = 1'b1;
    end
    if (phi < -64'sd2147483648) begin
      phi = -64'sd2147483648;
      sat = 1'b1;
    end
    return {degen, sat, phi[31:0]};
  endfunction

  function automatic bit quiet_window();
    return (cycle_cnt >= 2000 && cycle_cnt < 5000);
  endfunction

  // acceptance on both buses
  always @(posedge clk_i) begin
    logic [33:0] want;
    cycle_cnt <= cycle_cnt + 1;
    took = s_axis_tvalid && s_axis_tready;
    if (took) distance_queue = {distance_queue, shape_distance(s_axis_tdata)};
    if (m_axis_tvalid && m_axis_tready) begin
      if (distance_queue.size() == 0) begin
        $display("%0t: unexpected transaction distance %h tuser %b", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = distance_queue.pop_front();
        if (pending != 0) pending--;
        if (m_axis_tdata !== want[31:0]) begin
          $display("%0t: distance expected %h actual %h", $time, want[31:0], m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[TUSER_SAT] !== want[32]) begin
          $display("%0t: saturated expected %b actual %b", $time, want[32],
                   m_axis_tuser[TUSER_SAT]);
          errors++;
        end
        if (m_axis_tuser[TUSER_DEGEN] !== want[33]) begin
          $display("%0t: degenerate expected %b actual %b", $time, want[33],
                   m_axis_tuser[TUSER_DEGEN]);
          errors++;
        end
      end
    end
  end

  // point driver
  always @(negedge clk_i) begin
    logic        nv;
    logic [95:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!s_axis_tvalid || took) begin
      nv = 1'b0;
      if (rst_ni && point_queue.size() != 0 &&
          (quiet_window() || $urandom_range(99) >= 6)) begin
        nv = 1'b1;
        nd = point_queue.pop_front();
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
    m_axis_tready <= rst_ni && (quiet_window() || $urandom_range(99) >= 6);
  end

  task automatic add_point(logic [95:0] pt);
    point_queue = {point_queue, pt};
    pending++;
  endtask

  task automatic reg_write(reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx) << 3;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SHAPE_MODE: mode_q = value[2:0];
      REG_CENTER_X:   cx_q = value[31:0];
      REG_CENTER_Y:   cy_q = value[31:0];
      REG_CENTER_Z:   cz_q = value[31:0];
      REG_ROTATION:   rot_q = value;
      REG_DIM_A:      da_q = value[30:0];
      REG_DIM_B:      db_q = value[30:0];
      default:        dcd_q = value;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] centre);
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return centre + 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(0, 3 << 16);
    endcase
  endfunction

  function automatic logic [63:0] pick_rotation();
    case ($urandom_range(5))
      0: return 64'd16384;
      1: return {$urandom(), $urandom()};
      2: return {16'h8000, 16'h8000, 16'h8000, 16'h8000};
      3: return {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
      default: return {16'd0, 16'd0, 16'($urandom_range(0, 11585)), 16'd11585};
    endcase
  endfunction

  task automatic config_phase(logic [2:0] mode, bit extreme);
    logic [31:0] c[3];
    for (int k = 0; k < 3; k++)
      c[k] = extreme ? (k[0] ? 32'h8000_0000 : 32'h7fff_ffff)
                     : 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
    reg_write(REG_SHAPE_MODE, 64'(mode));
    reg_write(REG_CENTER_X, 64'(c[0]));
    reg_write(REG_CENTER_Y, 64'(c[1]));
    reg_write(REG_CENTER_Z, 64'(c[2]));
    reg_write(REG_ROTATION, extreme ? {16'h8000, 16'h7fff, 16'h8000, 16'h7fff}
                                    : pick_rotation());
    reg_write(REG_DIM_A, extreme ? 64'h7fff_ffff : 64'(pick_dim()));
    reg_write(REG_DIM_B, (mode[1:0] == KIND_CAPSULE && $urandom_range(2) == 0)
                         ? 64'd0 : 64'(pick_dim()));
    reg_write(REG_DIMS_CD, extreme ? 64'hffff_ffff_ffff_ffff
                                   : {pick_dim(), pick_dim()});
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: each shape and sign, corner points, extreme registers
    for (int md = 0; md < 8; md++) begin
      config_phase(3'(md), md == 7);
      add_point({cz_q, cy_q, cx_q});
      add_point({3{32'h7fff_ffff}});
      add_point({3{32'h8000_0000}});
      drain();
    end
    // degenerate capsule
    config_phase(3'(KIND_CAPSULE), 1'b0);
    reg_write(REG_DIM_B, 64'd0);
    add_point({cz_q, cy_q, cx_q + 32'h0002_0000});
    drain();
    // random phases
    for (int ph = 0; ph < 24; ph++) begin
      config_phase(3'($urandom_range(7)), ph == 12);
      for (int n = 0; n < 28; n++)
        add_point({pick_coord(cz_q), pick_coord(cy_q), pick_coord(cx_q)});
      drain();
    end
    repeat (120) @(negedge clk_i);
    if (errors == 0 && distance_queue.size() == 0) begin
      $display("[sdf_primitive_evaluator_core] OK");
    end else begin
      $display("[sdf_primitive_evaluator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[sdf_primitive_evaluator_core] ERROR");
    $finish;
  end

endmodule
